// File: rtl/core/lav_pkg.sv
package lav_pkg;

    // coordinate and translation words
    localparam int COORD_W     = 32;
    localparam int TRANS_W     = 32;
    // basis entries as seen on the ports
    localparam int BASIS_OUT_W = 18;
    // magnitudes are scaled so that the largest one sits in [2^29, 2^30)
    localparam int SCALE_W     = 30;
    localparam int SCALE_TOP   = 29;
    // integer square root of a sum of three scaled squares
    localparam int SQ_IN_W     = 62;
    localparam int SQ_ROOT_W   = 31;
    localparam int SQ_REM_W    = 33;
    localparam int SQ_STEPS    = 31;
    // divider partial remainder stays below the root
    localparam int DV_REM_W    = 31;

endpackage

// File: rtl/core/lav_isqrt.sv
module lav_isqrt
    import lav_pkg::*;
#(
    parameter int SW = 1
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [SQ_IN_W-1:0]   x,
    input  logic [SW-1:0]        side_in,
    output logic                 out_vld,
    output logic [SQ_ROOT_W-1:0] root,
    output logic [SW-1:0]        side_out
);

    logic [SQ_IN_W-1:0]   x_reg    [1:SQ_STEPS-1];
    logic [SQ_REM_W-1:0]  rem_reg  [1:SQ_STEPS-1];
    logic [SQ_ROOT_W-1:0] root_reg [1:SQ_STEPS];
    logic [SW-1:0]        side_reg [1:SQ_STEPS];
    logic                 vld_reg  [1:SQ_STEPS];

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic [SQ_IN_W-1:0]   x_cur;
        logic [SQ_REM_W-1:0]  rem_cur;
        logic [SQ_ROOT_W-1:0] root_cur;
        logic [SW-1:0]        side_cur;
        logic                 vld_cur;
        logic [SQ_REM_W+1:0]  acc;
        logic [SQ_REM_W+1:0]  trial;
        logic [SQ_REM_W-1:0]  rem_next;
        logic [SQ_ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign x_cur    = x;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = side_in;
            assign vld_cur  = in_vld;
        end
        else
        begin : g_rest
            assign x_cur    = x_reg[k];
            assign rem_cur  = rem_reg[k];
            assign root_cur = root_reg[k];
            assign side_cur = side_reg[k];
            assign vld_cur  = vld_reg[k];
        end

        always_comb
        begin
            acc   = {rem_cur, x_cur[SQ_IN_W-1-2*k -: 2]};
            trial = (SQ_REM_W+2)'({root_cur, 2'b01});
            if (acc >= trial)
            begin
                rem_next  = SQ_REM_W'(acc - trial);
                root_next = {root_cur[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = SQ_REM_W'(acc);
                root_next = {root_cur[SQ_ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k+1] <= root_next;
                side_reg[k+1] <= side_cur;
            end
        end

        if (k < SQ_STEPS-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k+1]   <= x_cur;
                    rem_reg[k+1] <= rem_next;
                end
            end
        end
    end

    assign out_vld  = vld_reg[SQ_STEPS];
    assign root     = root_reg[SQ_STEPS];
    assign side_out = side_reg[SQ_STEPS];

endmodule

// File: rtl/core/lav_div.sv
module lav_div
    import lav_pkg::*;
#(
    parameter int FB = 16,
    parameter int SW = 1
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_vld,
    input  logic [2:0][SCALE_W+FB:0]       num,
    input  logic [SQ_ROOT_W-1:0]           den,
    input  logic [SW-1:0]                  side_in,
    output logic                           out_vld,
    output logic [2:0][FB:0]               quo,
    output logic [SW-1:0]                  side_out
);

    localparam int QB = FB + 1;
    localparam int NW = SCALE_W + FB + 1;

    logic [2:0][DV_REM_W-1:0] rem_reg  [1:QB-1];
    logic [2:0][QB-1:0]       nlo_reg  [1:QB-1];
    logic [SQ_ROOT_W-1:0]     den_reg  [1:QB-1];
    logic [2:0][QB-1:0]       quo_reg  [1:QB];
    logic [SW-1:0]            side_reg [1:QB];
    logic                     vld_reg  [1:QB];

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar j = 0; j < QB; j++)
    begin : g_step
        logic [2:0][DV_REM_W-1:0] rem_cur;
        logic [2:0][QB-1:0]       nlo_cur;
        logic [SQ_ROOT_W-1:0]     den_cur;
        logic [2:0][QB-1:0]       quo_cur;
        logic [SW-1:0]            side_cur;
        logic                     vld_cur;
        logic [DV_REM_W:0]        acc;
        logic [2:0][DV_REM_W-1:0] rem_next;
        logic [2:0][QB-1:0]       quo_next;

        if (j == 0)
        begin : g_first
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_cur[l] = DV_REM_W'(num[l][NW-1:QB]);
                assign nlo_cur[l] = num[l][QB-1:0];
            end
            assign den_cur  = den;
            assign quo_cur  = '0;
            assign side_cur = side_in;
            assign vld_cur  = in_vld;
        end
        else
        begin : g_rest
            assign rem_cur  = rem_reg[j];
            assign nlo_cur  = nlo_reg[j];
            assign den_cur  = den_reg[j];
            assign quo_cur  = quo_reg[j];
            assign side_cur = side_reg[j];
            assign vld_cur  = vld_reg[j];
        end

        always_comb
        begin
            acc = '0;
            for (int l = 0; l < 3; l++)
            begin
                acc = {rem_cur[l], nlo_cur[l][QB-1-j]};
                if (acc >= (DV_REM_W+1)'(den_cur))
                begin
                    rem_next[l] = DV_REM_W'(acc - (DV_REM_W+1)'(den_cur));
                    quo_next[l] = {quo_cur[l][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = acc[DV_REM_W-1:0];
                    quo_next[l] = {quo_cur[l][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j+1] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j+1]  <= quo_next;
                side_reg[j+1] <= side_cur;
            end
        end

        if (j < QB-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= rem_next;
                    nlo_reg[j+1] <= nlo_cur;
                    den_reg[j+1] <= den_cur;
                end
            end
        end
    end

    assign out_vld  = vld_reg[QB];
    assign quo      = quo_reg[QB];
    assign side_out = side_reg[QB];

endmodule

// File: rtl/core/lav_norm.sv
module lav_norm
    import lav_pkg::*;
#(
    parameter int IW = 33,
    parameter int FB = 16,
    parameter int SW = 1
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [2:0][IW-1:0]    vec,
    input  logic [SW-1:0]         side_in,
    output logic                  out_vld,
    output logic [2:0][FB+1:0]    unit,
    output logic [SW-1:0]         side_out
);

    localparam int PW  = $clog2(IW);
    localparam int NG  = (IW + 7) / 8;
    localparam int QB  = FB + 1;
    localparam int NW  = SCALE_W + FB + 1;
    localparam int BW  = FB + 2;
    localparam int SQS = 3*SCALE_W + 4 + SW;
    localparam int DVS = 4 + SW;

    // stage 1: magnitudes
    logic                  vld1_reg;
    logic [2:0][IW-1:0]    mag1_reg, mag1_next;
    logic [2:0]            sgn1_reg;
    logic [SW-1:0]         side1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = vec[i][IW-1] ? ('0 - vec[i]) : vec[i];
        end
    end

    // stage 2: or of magnitudes, its top bit is the top bit of the largest
    logic                  vld2_reg;
    logic [2:0][IW-1:0]    mag2_reg;
    logic [2:0]            sgn2_reg;
    logic [SW-1:0]         side2_reg;
    logic [IW-1:0]         or2_reg, or2_next;

    assign or2_next = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];

    // stage 3: leading one, found per byte then across bytes
    logic                  vld3_reg;
    logic [2:0][IW-1:0]    mag3_reg;
    logic [2:0]            sgn3_reg;
    logic [SW-1:0]         side3_reg;
    logic [PW-1:0]         pos3_reg, pos3_next;
    logic                  zero3_reg, zero3_next;
    logic [NG*8-1:0]       pad;
    logic [7:0]            pos_w;

    always_comb
    begin
        pad   = (NG*8)'(or2_reg);
        pos_w = 8'd0;
        for (int g = 0; g < NG; g++)
        begin
            if (|pad[g*8 +: 8])
            begin
                for (int b = 0; b < 8; b++)
                begin
                    if (pad[g*8+b])
                    begin
                        pos_w = 8'(g*8 + b);
                    end
                end
            end
        end
        pos3_next  = PW'(pos_w);
        zero3_next = ~|or2_reg;
    end

    // stage 4: scale so the largest magnitude lands in [2^29, 2^30)
    logic                       vld4_reg;
    logic [2:0][SCALE_W-1:0]    mp4_reg, mp4_next;
    logic [2:0]                 sgn4_reg;
    logic [SW-1:0]              side4_reg;
    logic                       zero4_reg;
    logic [7:0]                 pos8;
    logic [IW+SCALE_W-1:0]      wide, sc;

    always_comb
    begin
        pos8 = 8'(pos3_reg);
        wide = '0;
        sc   = '0;
        for (int i = 0; i < 3; i++)
        begin
            wide = (IW+SCALE_W)'(mag3_reg[i]);
            if (pos8 > 8'(SCALE_TOP))
            begin
                sc = wide >> (pos8 - 8'(SCALE_TOP));
            end
            else
            begin
                sc = wide << (8'(SCALE_TOP) - pos8);
            end
            mp4_next[i] = sc[SCALE_W-1:0];
        end
    end

    // stage 5: squares
    logic                        vld5_reg;
    logic [2:0][SCALE_W-1:0]     mp5_reg;
    logic [2:0][2*SCALE_W-1:0]   sq5_reg, sq5_next;
    logic [2:0]                  sgn5_reg;
    logic [SW-1:0]               side5_reg;
    logic                        zero5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq5_next[i] = (2*SCALE_W)'(mp4_reg[i]) * (2*SCALE_W)'(mp4_reg[i]);
        end
    end

    // stage 6: sum of squares
    logic                        vld6_reg;
    logic [2:0][SCALE_W-1:0]     mp6_reg;
    logic [SQ_IN_W-1:0]          s2_reg, s2_next;
    logic [2:0]                  sgn6_reg;
    logic [SW-1:0]               side6_reg;
    logic                        zero6_reg;

    assign s2_next = SQ_IN_W'(sq5_reg[0]) + SQ_IN_W'(sq5_reg[1]) + SQ_IN_W'(sq5_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            sgn1_reg  <= {vec[2][IW-1], vec[1][IW-1], vec[0][IW-1]};
            side1_reg <= side_in;

            mag2_reg  <= mag1_reg;
            sgn2_reg  <= sgn1_reg;
            side2_reg <= side1_reg;
            or2_reg   <= or2_next;

            mag3_reg  <= mag2_reg;
            sgn3_reg  <= sgn2_reg;
            side3_reg <= side2_reg;
            pos3_reg  <= pos3_next;
            zero3_reg <= zero3_next;

            mp4_reg   <= mp4_next;
            sgn4_reg  <= sgn3_reg;
            side4_reg <= side3_reg;
            zero4_reg <= zero3_reg;

            mp5_reg   <= mp4_reg;
            sq5_reg   <= sq5_next;
            sgn5_reg  <= sgn4_reg;
            side5_reg <= side4_reg;
            zero5_reg <= zero4_reg;

            mp6_reg   <= mp5_reg;
            s2_reg    <= s2_next;
            sgn6_reg  <= sgn5_reg;
            side6_reg <= side5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // root of the sum of squares
    logic                       sq_vld;
    logic [SQ_ROOT_W-1:0]       sq_root;
    logic [SQS-1:0]             sq_side;
    logic [2:0][SCALE_W-1:0]    mp_s;
    logic [2:0]                 sgn_s;
    logic                       zero_s;
    logic [SW-1:0]              side_s;

    lav_isqrt #(
        .SW (SQS)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld6_reg),
        .x        (s2_reg),
        .side_in  ({mp6_reg, sgn6_reg, zero6_reg, side6_reg}),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    assign {mp_s, sgn_s, zero_s, side_s} = sq_side;

    // stage 7: rounded numerators
    logic                   vld7_reg;
    logic [2:0][NW-1:0]     num7_reg, num7_next;
    logic [SQ_ROOT_W-1:0]   den7_reg;
    logic [2:0]             sgn7_reg;
    logic                   zero7_reg;
    logic [SW-1:0]          side7_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num7_next[i] = (NW'(mp_s[i]) << FB) + NW'(sq_root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld7_reg <= 1'b0;
        end
        else if (en)
        begin
            vld7_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num7_reg  <= num7_next;
            den7_reg  <= sq_root;
            sgn7_reg  <= sgn_s;
            zero7_reg <= zero_s;
            side7_reg <= side_s;
        end
    end

    logic                   dv_vld;
    logic [2:0][QB-1:0]     dv_quo;
    logic [DVS-1:0]         dv_side;
    logic [2:0]             sgn_d;
    logic                   zero_d;
    logic [SW-1:0]          side_d;

    lav_div #(
        .FB (FB),
        .SW (DVS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld7_reg),
        .num      (num7_reg),
        .den      (den7_reg),
        .side_in  ({sgn7_reg, zero7_reg, side7_reg}),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    assign {sgn_d, zero_d, side_d} = dv_side;

    // stage 8: clamp to one, restore sign, zero vector stays zero
    logic                   vld8_reg;
    logic [2:0][BW-1:0]     unit8_reg, unit8_next;
    logic [SW-1:0]          side8_reg;
    logic [QB-1:0]          q;

    always_comb
    begin
        q = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = dv_quo[i];
            if (q > (QB'(1) << FB))
            begin
                q = QB'(1) << FB;
            end
            if (zero_d)
            begin
                unit8_next[i] = '0;
            end
            else if (sgn_d[i])
            begin
                unit8_next[i] = '0 - BW'(q);
            end
            else
            begin
                unit8_next[i] = BW'(q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld8_reg <= 1'b0;
        end
        else if (en)
        begin
            vld8_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit8_reg <= unit8_next;
            side8_reg <= side_d;
        end
    end

    assign out_vld  = vld8_reg;
    assign unit     = unit8_reg;
    assign side_out = side8_reg;

endmodule

// File: rtl/core/lav_dot.sv
module lav_dot
    import lav_pkg::*;
#(
    parameter int FB = 16
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [8:0][FB+1:0]          basis,
    input  logic [2:0][COORD_W-1:0]     eye,
    output logic                        out_vld,
    output logic [8:0][FB+1:0]          basis_out,
    output logic [2:0][TRANS_W-1:0]     trans
);

    localparam int BW  = FB + 2;
    localparam int PRW = BW + COORD_W;
    localparam int DW  = PRW + 2;
    localparam int RW  = DW - FB;

    // stage 1: nine products
    logic                    vld1_reg;
    logic [8:0][BW-1:0]      bas1_reg;
    logic [8:0][PRW-1:0]     prod1_reg, prod1_next;
    logic signed [PRW-1:0]   pa, pe;

    always_comb
    begin
        pa = '0;
        pe = '0;
        for (int d = 0; d < 3; d++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa = PRW'($signed(basis[3*d+i]));
                pe = PRW'($signed(eye[i]));
                prod1_next[3*d+i] = pa * pe;
            end
        end
    end

    // stage 2: negated sums
    logic                    vld2_reg;
    logic [8:0][BW-1:0]      bas2_reg;
    logic [2:0][DW-1:0]      t2_reg, t2_next;
    logic signed [DW-1:0]    acc;

    always_comb
    begin
        acc = '0;
        for (int d = 0; d < 3; d++)
        begin
            acc = DW'($signed(prod1_reg[3*d])) + DW'($signed(prod1_reg[3*d+1]))
                + DW'($signed(prod1_reg[3*d+2]));
            t2_next[d] = '0 - acc;
        end
    end

    // stage 3: round half away from zero, saturate
    logic                    vld3_reg;
    logic [8:0][BW-1:0]      bas3_reg;
    logic [2:0][TRANS_W-1:0] tr3_reg, tr3_next;
    logic [DW-1:0]           mg;
    logic [RW-1:0]           rnd;

    always_comb
    begin
        mg  = '0;
        rnd = '0;
        for (int d = 0; d < 3; d++)
        begin
            mg  = t2_reg[d][DW-1] ? ('0 - t2_reg[d]) : t2_reg[d];
            rnd = RW'((mg + (DW'(1) << (FB-1))) >> FB);
            if (t2_reg[d][DW-1])
            begin
                if (rnd > (RW'(1) << (TRANS_W-1)))
                begin
                    tr3_next[d] = {1'b1, {(TRANS_W-1){1'b0}}};
                end
                else
                begin
                    tr3_next[d] = '0 - TRANS_W'(rnd);
                end
            end
            else
            begin
                if (rnd > RW'({1'b0, {(TRANS_W-1){1'b1}}}))
                begin
                    tr3_next[d] = {1'b0, {(TRANS_W-1){1'b1}}};
                end
                else
                begin
                    tr3_next[d] = TRANS_W'(rnd);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bas1_reg  <= basis;
            prod1_reg <= prod1_next;
            bas2_reg  <= bas1_reg;
            t2_reg    <= t2_next;
            bas3_reg  <= bas2_reg;
            tr3_reg   <= tr3_next;
        end
    end

    assign out_vld   = vld3_reg;
    assign basis_out = bas3_reg;
    assign trans     = tr3_reg;

endmodule

// File: rtl/core/look_at_view_matrix_top.sv
// look-at view matrix builder: each word carries a target and an eye point in
// signed fixed point (FRAC_BITS fraction bits) and yields the nine rotation
// entries (right, up, forward, each a unit vector) and the three saturated
// translations -dot(basis, eye). the datapath is a fully pipelined chain of
// three normalizers (forward, right, up), each with a one-bit-per-stage
// square root and divider, so a new word is taken every cycle while in_stall
// is low. vectors of zero length come out as zero. a two-entry output buffer
// lets the pipeline take one more word while out_stall holds the output;
// in_stall is high only while that buffer is full, and then every stage
// holds. with FRAC_BITS above 16 the basis entries wrap to 18 bits.
module look_at_view_matrix_top
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [COORD_W-1:0]        target_x,
    input  logic [COORD_W-1:0]        target_y,
    input  logic [COORD_W-1:0]        target_z,
    input  logic [COORD_W-1:0]        eye_x,
    input  logic [COORD_W-1:0]        eye_y,
    input  logic [COORD_W-1:0]        eye_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [BASIS_OUT_W-1:0]    right_x,
    output logic [BASIS_OUT_W-1:0]    right_y,
    output logic [BASIS_OUT_W-1:0]    right_z,
    output logic [BASIS_OUT_W-1:0]    up_x,
    output logic [BASIS_OUT_W-1:0]    up_y,
    output logic [BASIS_OUT_W-1:0]    up_z,
    output logic [BASIS_OUT_W-1:0]    fwd_x,
    output logic [BASIS_OUT_W-1:0]    fwd_y,
    output logic [BASIS_OUT_W-1:0]    fwd_z,
    output logic [TRANS_W-1:0]        trans_x,
    output logic [TRANS_W-1:0]        trans_y,
    output logic [TRANS_W-1:0]        trans_z
);

    localparam int FB      = FRAC_BITS;
    localparam int BW      = FB + 2;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PU      = 2 * BW;
    localparam int EYE_W   = 3 * COORD_W;
    localparam int ONE_FX  = 1 << FB;

    // whole pipeline advances unless the output skid entry is occupied
    logic en;
    logic sv_reg, sv_next;
    logic ov_reg, ov_next;

    assign en       = !sv_reg;
    assign in_stall = sv_reg;

    // input stage: direction and eye
    logic                       vld0_reg;
    logic [2:0][DIFF_W-1:0]     diff0_reg, diff0_next;
    logic [2:0][COORD_W-1:0]    eye0_reg, eye_in;
    logic [2:0][COORD_W-1:0]    tgt_in;

    assign tgt_in = {target_z, target_y, target_x};
    assign eye_in = {eye_z, eye_y, eye_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff0_next[i] = {tgt_in[i][COORD_W-1], tgt_in[i]}
                          - {eye_in[i][COORD_W-1], eye_in[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff0_reg <= diff0_next;
            eye0_reg  <= eye_in;
        end
    end

    // forward = normalize(target - eye)
    logic                     f_vld;
    logic [2:0][BW-1:0]       f_unit;
    logic [EYE_W-1:0]         f_side;

    lav_norm #(
        .IW (DIFF_W),
        .FB (FB),
        .SW (EYE_W)
    ) u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld0_reg),
        .vec      (diff0_reg),
        .side_in  (eye0_reg),
        .out_vld  (f_vld),
        .unit     (f_unit),
        .side_out (f_side)
    );

    // right = normalize(forward x (0,1,0)) = normalize(-fz, 0, fx)
    logic [2:0][BW-1:0]       rr_vec;
    logic                     r_vld;
    logic [2:0][BW-1:0]       r_unit;
    logic [EYE_W+3*BW-1:0]    r_side;
    logic [2:0][COORD_W-1:0]  eye_r;
    logic [2:0][BW-1:0]       f_r;

    assign rr_vec[0] = '0 - f_unit[2];
    assign rr_vec[1] = '0;
    assign rr_vec[2] = f_unit[0];

    lav_norm #(
        .IW (BW),
        .FB (FB),
        .SW (EYE_W + 3*BW)
    ) u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .vec      (rr_vec),
        .side_in  ({f_side, f_unit}),
        .out_vld  (r_vld),
        .unit     (r_unit),
        .side_out (r_side)
    );

    assign {eye_r, f_r} = r_side;

    // up input = forward x right, exact; ry is always zero
    logic                     vldu1_reg, vldu2_reg;
    logic [PU-1:0]            pa1_reg, pb1_reg, pc1_reg, pd1_reg;
    logic signed [PU-1:0]     pa_next, pb_next, pc_next, pd_next;
    logic [2:0][PU-1:0]       uu2_reg;
    logic [2:0][COORD_W-1:0]  eye_u1_reg, eye_u2_reg;
    logic [2:0][BW-1:0]       f_u1_reg, f_u2_reg, r_u1_reg, r_u2_reg;

    always_comb
    begin
        pa_next = PU'($signed(f_r[1])) * PU'($signed(r_unit[2]));
        pb_next = PU'($signed(f_r[2])) * PU'($signed(r_unit[0]));
        pc_next = PU'($signed(r_unit[2])) * PU'($signed(f_r[0]));
        pd_next = PU'($signed(r_unit[0])) * PU'($signed(f_r[1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldu1_reg <= 1'b0;
            vldu2_reg <= 1'b0;
        end
        else if (en)
        begin
            vldu1_reg <= r_vld;
            vldu2_reg <= vldu1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa1_reg    <= pa_next;
            pb1_reg    <= pb_next;
            pc1_reg    <= pc_next;
            pd1_reg    <= pd_next;
            eye_u1_reg <= eye_r;
            f_u1_reg   <= f_r;
            r_u1_reg   <= r_unit;

            uu2_reg[0] <= pa1_reg;
            uu2_reg[1] <= pb1_reg - pc1_reg;
            uu2_reg[2] <= '0 - pd1_reg;
            eye_u2_reg <= eye_u1_reg;
            f_u2_reg   <= f_u1_reg;
            r_u2_reg   <= r_u1_reg;
        end
    end

    // up = normalize(forward x right)
    logic                     u_vld;
    logic [2:0][BW-1:0]       u_unit;
    logic [EYE_W+6*BW-1:0]    u_side;
    logic [2:0][COORD_W-1:0]  eye_d;
    logic [2:0][BW-1:0]       f_d, r_d;

    lav_norm #(
        .IW (PU),
        .FB (FB),
        .SW (EYE_W + 6*BW)
    ) u_norm_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vldu2_reg),
        .vec      (uu2_reg),
        .side_in  ({eye_u2_reg, f_u2_reg, r_u2_reg}),
        .out_vld  (u_vld),
        .unit     (u_unit),
        .side_out (u_side)
    );

    assign {eye_d, f_d, r_d} = u_side;

    // translations
    logic [8:0][BW-1:0]       bas_in, bas_out;
    logic [2:0][TRANS_W-1:0]  tr_out;
    logic                     d_vld;

    assign bas_in = {f_d, u_unit, r_d};

    lav_dot #(
        .FB (FB)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (u_vld),
        .basis     (bas_in),
        .eye       (eye_d),
        .out_vld   (d_vld),
        .basis_out (bas_out),
        .trans     (tr_out)
    );

    // output word plus one skid entry
    logic                     take;
    logic                     load_o, load_s, from_skid;
    logic [8:0][BW-1:0]       ob_reg, sb_reg;
    logic [2:0][TRANS_W-1:0]  ot_reg, st_reg;

    always_comb
    begin
        take      = ov_reg && !out_stall;
        ov_next   = ov_reg;
        sv_next   = sv_reg;
        load_o    = 1'b0;
        load_s    = 1'b0;
        from_skid = 1'b0;
        if (sv_reg)
        begin
            if (take)
            begin
                from_skid = 1'b1;
                sv_next   = 1'b0;
            end
        end
        else if (d_vld)
        begin
            if (ov_reg && !take)
            begin
                load_s  = 1'b1;
                sv_next = 1'b1;
            end
            else
            begin
                load_o  = 1'b1;
                ov_next = 1'b1;
            end
        end
        else if (take)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (from_skid)
        begin
            ob_reg <= sb_reg;
            ot_reg <= st_reg;
        end
        else if (load_o)
        begin
            ob_reg <= bas_out;
            ot_reg <= tr_out;
        end
        if (load_s)
        begin
            sb_reg <= bas_out;
            st_reg <= tr_out;
        end
    end

    // basis entries to port width, sign extended or wrapped
    logic [8:0][BASIS_OUT_W-1:0] bo;

    for (genvar k = 0; k < 9; k++)
    begin : g_bout
        logic [BW+BASIS_OUT_W-1:0] ext;
        assign ext   = {{BASIS_OUT_W{ob_reg[k][BW-1]}}, ob_reg[k]};
        assign bo[k] = ext[BASIS_OUT_W-1:0];
    end

    assign out_valid = ov_reg;
    assign right_x   = bo[0];
    assign right_y   = bo[1];
    assign right_z   = bo[2];
    assign up_x      = bo[3];
    assign up_y      = bo[4];
    assign up_z      = bo[5];
    assign fwd_x     = bo[6];
    assign fwd_y     = bo[7];
    assign fwd_z     = bo[8];
    assign trans_x   = ot_reg[0];
    assign trans_y   = ot_reg[1];
    assign trans_z   = ot_reg[2];

`ifndef SYNTH
    // skid entry only ever sits behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg |-> ov_reg)
        else $error("skid entry valid with empty output register");

    // a held skid word is not dropped while the output is stalled
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg && out_stall) |=> sv_reg)
        else $error("skid word lost under stall");

    // skid drains into the output register once the output is taken
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (sv_reg && !out_stall) |=> (ov_reg && !sv_reg))
        else $error("skid word not moved to output");

    // normalized forward stays within plus or minus one
    a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld |-> ($signed(f_unit[0]) <= ONE_FX && $signed(f_unit[0]) >= -ONE_FX
                && $signed(f_unit[1]) <= ONE_FX && $signed(f_unit[1]) >= -ONE_FX
                && $signed(f_unit[2]) <= ONE_FX && $signed(f_unit[2]) >= -ONE_FX))
        else $error("forward component out of unit range");
`endif

endmodule

// File: tb/tb_look_at_view_matrix_top.sv
`timescale 1ns / 100ps

module tb_look_at_view_matrix_top;
    import lav_pkg::*;

    localparam int FB          = 16;
    localparam int PIPE_DEPTH  = 3 * FB + 127;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_WORDS  = 630;
    // more than the pipeline holds, so the input is stalled during the hold-off
    localparam int PRESS_WORDS = 200;

    typedef longint vec3_t [3];

    // one input word: target x/y/z then eye x/y/z
    typedef struct packed {
        logic [5:0][COORD_W-1:0] pt;
    } points_t;

    // one output word: right, up, forward (x/y/z each), then translations
    typedef struct packed {
        logic [8:0][BASIS_OUT_W-1:0] basis;
        logic [2:0][TRANS_W-1:0]     trans;
    } view_mtx_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [COORD_W-1:0] target_x, target_y, target_z, eye_x, eye_y, eye_z;
    logic out_valid;
    logic out_stall;
    logic [BASIS_OUT_W-1:0] right_x, right_y, right_z, up_x, up_y, up_z;
    logic [BASIS_OUT_W-1:0] fwd_x, fwd_y, fwd_z;
    logic [TRANS_W-1:0] trans_x, trans_y, trans_z;

    // matrices still owed by the block, oldest first
    view_mtx_t pending_mtx [$];
    int  mismatch_cnt;
    bit  failed;
    int  cycle_cnt;
    // receiver hold-off, raised by the back-pressure test
    bit  hold_off;
    // sender burst bookkeeping
    int  burst_left;

    look_at_view_matrix_top #(
        .FRAC_BITS (FB)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .eye_x     (eye_x),
        .eye_y     (eye_y),
        .eye_z     (eye_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .right_x   (right_x),
        .right_y   (right_y),
        .right_z   (right_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z),
        .fwd_x     (fwd_x),
        .fwd_y     (fwd_y),
        .fwd_z     (fwd_z),
        .trans_x   (trans_x),
        .trans_y   (trans_y),
        .trans_z   (trans_z)
    );

    always #1 clk = ~clk;

    // bit-serial integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x    -= root + bitv;
                root  = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // scale so the largest magnitude sits in [2^29, 2^30), then divide by the length
    function automatic vec3_t unit_vec(vec3_t v);
        vec3_t           o;
        longint unsigned m [3];
        longint unsigned mx, sum_sq, len, q;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? longint'(0) - v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            o = '{0, 0, 0};
            return o;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
        end
        sum_sq = 0;
        for (int i = 0; i < 3; i++)
            sum_sq += m[i] * m[i];
        len = int_sqrt(sum_sq);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            if (q > (64'd1 << FB))
                q = 64'd1 << FB;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    // -dot(a, eye), rounded half away from zero, saturated to 32 bits
    function automatic logic [TRANS_W-1:0] eye_offset(vec3_t a, vec3_t eye);
        longint          t;
        longint unsigned mg, r;
        t  = -(a[0] * eye[0] + a[1] * eye[1] + a[2] * eye[2]);
        mg = (t < 0) ? longint'(0) - t : t;
        r  = (mg + (64'd1 << (FB - 1))) >> FB;
        if (t < 0)
        begin
            if (r > 64'h8000_0000)
                r = 64'h8000_0000;
            return TRANS_W'(-longint'(r));
        end
        if (r > 64'h7FFF_FFFF)
            r = 64'h7FFF_FFFF;
        return TRANS_W'(r);
    endfunction

    function automatic view_mtx_t build_view(points_t w);
        view_mtx_t mtx;
        vec3_t     eye, dir, fwd, side_raw, side, up_raw, up;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(w.pt[3 + i]));
            dir[i] = longint'($signed(w.pt[i])) - eye[i];
        end
        fwd      = unit_vec(dir);
        side_raw = '{-fwd[2], 0, fwd[0]};
        side     = unit_vec(side_raw);
        up_raw   = '{fwd[1] * side[2] - side[1] * fwd[2],
                     fwd[2] * side[0] - side[2] * fwd[0],
                     fwd[0] * side[1] - side[0] * fwd[1]};
        up       = unit_vec(up_raw);
        // packed arrays count down, so field k sits at index 8-k / 2-k
        for (int i = 0; i < 3; i++)
        begin
            mtx.basis[8 - i] = BASIS_OUT_W'(side[i]);
            mtx.basis[5 - i] = BASIS_OUT_W'(up[i]);
            mtx.basis[2 - i] = BASIS_OUT_W'(fwd[i]);
        end
        mtx.trans[2] = eye_offset(side, eye);
        mtx.trans[1] = eye_offset(up, eye);
        mtx.trans[0] = eye_offset(fwd, eye);
        return mtx;
    endfunction

    // offer one word, hold it until taken, then maybe go idle for a while
    task automatic send_word(points_t w);
        int gap;
        in_valid <= 1'b1;
        target_x <= w.pt[0];
        target_y <= w.pt[1];
        target_z <= w.pt[2];
        eye_x    <= w.pt[3];
        eye_y    <= w.pt[4];
        eye_z    <= w.pt[5];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_mtx.push_back(build_view(w));
        burst_left--;
        if (burst_left <= 0)
        begin
            // long bursts now and then give stretches with no idling
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    function automatic points_t make_points(logic [COORD_W-1:0] tx, logic [COORD_W-1:0] ty,
                                            logic [COORD_W-1:0] tz, logic [COORD_W-1:0] ex,
                                            logic [COORD_W-1:0] ey, logic [COORD_W-1:0] ez);
        points_t w;
        w.pt = '{ez, ey, ex, tz, ty, tx};
        return w;
    endfunction

    // random point pair: mostly general geometry, with degenerate shapes mixed in
    function automatic points_t rand_points();
        points_t w;
        int      kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
        begin
            if (kind <= 3)
                w.pt[i] = $urandom;
            else
                w.pt[i] = COORD_W'($signed($urandom_range(0, 2000000)) - 1000000);
        end
        case (kind)
            6: w.pt[2:0] = w.pt[5:3];                          // target on the eye
            7:
            begin                                              // looking straight up/down
                w.pt[0] = w.pt[3];
                w.pt[2] = w.pt[5];
            end
            8: w.pt[2:0] = w.pt[5:3] + {32'd0, 32'd0, 32'($urandom_range(1, 3))};
            default: ;
        endcase
        return w;
    endfunction

    // extremes of every coordinate and axis-aligned directions
    task automatic test_extremes();
        logic [COORD_W-1:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_word(make_points(mx, mx, mx, mn, mn, mn));
        send_word(make_points(mn, mn, mn, mx, mx, mx));
        send_word(make_points(mx, mn, mx, mn, mx, mn));
        send_word(make_points(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        send_word(make_points(32'h0001_0000, 0, 0, 0, 0, 0));
        send_word(make_points(0, 0, 32'h0001_0000, 0, 0, 0));
        send_word(make_points(0, 0, 1, mx, mx, mx));
        send_word(make_points(1, 0, 0, mn, mn, mn));
        send_word(make_points(0, 0, 0, 32'h0003_0000, 32'h0002_0000, 32'h0005_0000));
        send_word(make_points(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        send_word(make_points(1, 1, 1, 0, 0, 0));
        send_word(make_points(mx, 0, mx, mn, 0, mn));
    endtask

    // zero-length forward, vertical forward (right and up collapse to zero) and forward along z
    task automatic test_degenerate();
        send_word(make_points(0, 0, 0, 0, 0, 0));
        send_word(make_points(32'h1234_5678, 32'h8765_4321, 32'h0BAD_F00D,
                              32'h1234_5678, 32'h8765_4321, 32'h0BAD_F00D));
        send_word(make_points(32'h0002_0000, 32'h0009_0000, 32'h0003_0000,
                              32'h0002_0000, 32'h0001_0000, 32'h0003_0000));
        send_word(make_points(5, 0, 7, 5, 32'h7FFF_FFFF, 7));
        send_word(make_points(5, 32'h8000_0000, 7, 5, 32'h7FFF_FFFF, 7));
        send_word(make_points(0, 1, 0, 0, 0, 0));
        send_word(make_points(0, 0, 1, 0, 0, 0));
    endtask

    task automatic test_random();
        for (int n = 0; n < RAND_WORDS; n++)
            send_word(rand_points());
    endtask

    // receiver holds off long enough for the pipeline and output buffer to fill
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (PIPE_DEPTH + 200)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int n = 0; n < PRESS_WORDS; n++)
                    send_word(rand_points());
            end
        join
    endtask

    // result checker and receiver stall pattern
    int        stall_pct;
    int        phase_cnt;
    view_mtx_t got_mtx;
    view_mtx_t want_mtx;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_mtx.basis = {right_x, right_y, right_z, up_x, up_y, up_z,
                             fwd_x, fwd_y, fwd_z};
            got_mtx.trans = {trans_x, trans_y, trans_z};
            if (pending_mtx.size() == 0)
            begin
                failed = 1'b1;
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word at cycle %0d", cycle_cnt);
            end
            else
            begin
                want_mtx = pending_mtx.pop_front();
                for (int k = 0; k < 12; k++)
                begin
                    if (k < 9 ? got_mtx.basis[8 - k] !== want_mtx.basis[8 - k]
                              : got_mtx.trans[11 - k] !== want_mtx.trans[11 - k])
                    begin
                        failed = 1'b1;
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("field %0d mismatch at cycle %0d: expected %h got %h",
                                     k, cycle_cnt,
                                     k < 9 ? 32'(want_mtx.basis[8 - k])
                                           : want_mtx.trans[11 - k],
                                     k < 9 ? 32'(got_mtx.basis[8 - k])
                                           : got_mtx.trans[11 - k]);
                    end
                end
            end
        end
        // stall density is redrawn each time phase_cnt wraps, including stretches of none
        phase_cnt++;
        if (phase_cnt >= 64)
        begin
            phase_cnt = 0;
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL look_at_view_matrix_top");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        target_x     = '0;
        target_y     = '0;
        target_z     = '0;
        eye_x        = '0;
        eye_y        = '0;
        eye_z        = '0;
        hold_off     = 1'b0;
        failed       = 1'b0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        stall_pct    = 0;
        phase_cnt    = 0;
        burst_left   = 1;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_degenerate();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;

        // drain, then give any stray word time to show up
        while (pending_mtx.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 50)
            @(posedge clk);

        if (!failed)
            $display("PASS look_at_view_matrix_top");
        else
            $display("FAIL look_at_view_matrix_top");
        $finish;
    end

endmodule
